[hdl/isp_pkg.sv]
// Package for the infix-to-postfix converter: payload structs, character codes,
// precedence function and the command/status structs between controller and datapath.
// No dependencies.
package isp_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);

  localparam logic [7:0] CH_POW    = 8'h5E;  // '^'
  localparam logic [7:0] CH_LPAREN = 8'h28;  // '('
  localparam logic [7:0] CH_RPAREN = 8'h29;  // ')'
  localparam logic [7:0] CH_MUL    = 8'h2A;  // '*'
  localparam logic [7:0] CH_DIV    = 8'h2F;  // '/'
  localparam logic [7:0] CH_ADD    = 8'h2B;  // '+'
  localparam logic [7:0] CH_SUB    = 8'h2D;  // '-'

  localparam logic [1:0] PREC_NONE = 2'd0;
  localparam logic [1:0] PREC_ADD  = 2'd1;
  localparam logic [1:0] PREC_MUL  = 2'd2;
  localparam logic [1:0] PREC_POW  = 2'd3;

  typedef struct packed {
    logic [7:0] in_char;
    logic       end_of_expr;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       last_of_run;
    logic       expr_done;
    logic       overflow;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load;      // capture the accepted input item
    logic push;      // push current char (dropped and flagged when full)
    logic pop;       // drop top of stack
    logic emit;      // place a char in the pending slot
    logic emit_top;  // emit source: 1 top of stack, 0 current char
    logic finish;    // close the run: send pending as last, or a bare marker
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic       cur_lparen;
    logic       cur_rparen;
    logic [1:0] cur_prec;
    logic       top_lparen;
    logic       pops_cur;     // top outranks or equals the current operator
    logic       stack_empty;
    logic       pend_full;
    logic       out_free;
    logic       end_flag;
  } dp_status_t;

  function automatic logic [1:0] prec(input logic [7:0] c);
    logic [1:0] p;
    p = PREC_NONE;
    unique case (c)
      CH_POW:         p = PREC_POW;
      CH_MUL, CH_DIV: p = PREC_MUL;
      CH_ADD, CH_SUB: p = PREC_ADD;
      default:        p = PREC_NONE;
    endcase
    return p;
  endfunction

endpackage

[hdl/infix_to_postfix_converter.sv]
// Infix-to-postfix converter (shunting-yard) top level: controller plus datapath.
// Depends on isp_pkg, isp_ctrl and isp_dp. Items are taken one at a time: the next is
// accepted only once the last has been classified, its pops and push done and, at an
// end of expression, the stack flushed. Operators pop one per cycle while the output
// is not stalled. Reset (rst, synchronous): empty stack, clear overflow, drop any
// pending result.
module infix_to_postfix_converter (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  isp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output isp_pkg::out_item_t out_data
);

  // Command and status buses between the two halves
  isp_pkg::ctrl_cmd_t  cmd;
  isp_pkg::dp_status_t st;

  // Sequence one input character at a time: classify it, pop what it releases,
  // push it if it is an operator or '(', flush on end of expression, then
  // release the held last result with its end flags.
  isp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // Hold the operator stack, the pending result and the output register.
  // The output register frees the input side: a new character may transfer
  // while a finished result still waits for out_ready.
  isp_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[hdl/isp_dp.sv]
// Datapath of the infix-to-postfix converter: input latch, operator stack memory,
// pending result slot, output register and sticky overflow flag. Uses isp_pkg.
module isp_dp (
  input  logic                clk,
  input  logic                rst,
  input  isp_pkg::in_item_t   in_data,
  input  isp_pkg::ctrl_cmd_t  cmd,
  output isp_pkg::dp_status_t st,
  output logic                out_valid,
  input  logic                out_ready,
  output isp_pkg::out_item_t  out_data
);

  logic [7:0]               cur_char;
  logic                     end_flag;
  logic [7:0]               stack_mem [isp_pkg::STACK_DEPTH];
  logic [7:0]               top;
  logic [isp_pkg::CNT_W-1:0] count;
  logic [isp_pkg::CNT_W-1:0] below_top;
  logic [7:0]               pend_char;
  logic                     pend_full;
  logic                     ovf;
  logic                     full;
  logic                     out_free;

  assign full      = (count == isp_pkg::CNT_W'(isp_pkg::STACK_DEPTH));
  assign below_top = count - isp_pkg::CNT_W'(2);
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    st.cur_lparen  = (cur_char == isp_pkg::CH_LPAREN);
    st.cur_rparen  = (cur_char == isp_pkg::CH_RPAREN);
    st.cur_prec    = isp_pkg::prec(cur_char);
    st.top_lparen  = (top == isp_pkg::CH_LPAREN);
    st.pops_cur    = (isp_pkg::prec(cur_char) <= isp_pkg::prec(top));
    st.stack_empty = (count == '0);
    st.pend_full   = pend_full;
    st.out_free    = out_free;
    st.end_flag    = end_flag;
  end

  // input latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_char <= in_data.in_char;
      end_flag <= in_data.end_of_expr;
    end
  end

  // stack memory: one write port, one registered read port feeding top
  always_ff @(posedge clk) begin
    if (cmd.push && !full) begin
      stack_mem[count[isp_pkg::ADDR_W-1:0]] <= cur_char;
      top <= cur_char;
    end else if (cmd.pop) begin
      top <= stack_mem[below_top[isp_pkg::ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.push && !full) begin
      count <= count + isp_pkg::CNT_W'(1);
    end else if (cmd.pop) begin
      count <= count - isp_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovf <= 1'b0;
    end else if (cmd.push && full) begin
      ovf <= 1'b1;
    end else if (cmd.finish && end_flag) begin
      ovf <= 1'b0;
    end
  end

  // pending slot: holds the newest char until we know whether it ends the run
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_full <= 1'b0;
    end else if (cmd.emit) begin
      pend_full <= 1'b1;
    end else if (cmd.finish) begin
      pend_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pend_char <= cmd.emit_top ? top : cur_char;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((cmd.emit && pend_full) || (cmd.finish && (pend_full || end_flag))) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit && pend_full) begin
      out_data <= '{out_char: pend_char, char_valid: 1'b1, last_of_run: 1'b0,
                    expr_done: 1'b0, overflow: ovf};
    end else if (cmd.finish && pend_full) begin
      out_data <= '{out_char: pend_char, char_valid: 1'b1, last_of_run: 1'b1,
                    expr_done: end_flag, overflow: ovf};
    end else if (cmd.finish && end_flag) begin
      out_data <= '{out_char: 8'h00, char_valid: 1'b0, last_of_run: 1'b1,
                    expr_done: 1'b1, overflow: ovf};
    end
  end

endmodule

[hdl/isp_ctrl.sv]
// Controller of the infix-to-postfix converter: one-hot state machine that
// sequences pops, pushes and result release. Uses isp_pkg.
module isp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  isp_pkg::dp_status_t st,
  output isp_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_PROC   = 6'b000010,
    S_RPAREN = 6'b000100,
    S_OPPOP  = 6'b001000,
    S_FLUSH  = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   emit_ok;
  logic   fin_ok;
  state_t after_char;

  assign emit_ok    = !st.pend_full || st.out_free;
  assign fin_ok     = !(st.pend_full || st.end_flag) || st.out_free;
  assign after_char = st.end_flag ? S_FLUSH : S_FINISH;

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_PROC;
        end
      end
      S_PROC: begin
        if (st.cur_lparen) begin
          cmd.push   = 1'b1;
          state_next = after_char;
        end else if (st.cur_rparen) begin
          state_next = S_RPAREN;
        end else if (st.cur_prec != isp_pkg::PREC_NONE) begin
          state_next = S_OPPOP;
        end else if (emit_ok) begin
          cmd.emit   = 1'b1;
          state_next = after_char;
        end
      end
      S_RPAREN: begin
        if (!st.stack_empty && !st.top_lparen) begin
          if (emit_ok) begin
            cmd.emit     = 1'b1;
            cmd.emit_top = 1'b1;
            cmd.pop      = 1'b1;
          end
        end else begin
          cmd.pop    = !st.stack_empty;
          state_next = after_char;
        end
      end
      S_OPPOP: begin
        if (!st.stack_empty && !st.top_lparen && st.pops_cur) begin
          if (emit_ok) begin
            cmd.emit     = 1'b1;
            cmd.emit_top = 1'b1;
            cmd.pop      = 1'b1;
          end
        end else begin
          cmd.push   = 1'b1;
          state_next = after_char;
        end
      end
      S_FLUSH: begin
        if (!st.stack_empty) begin
          if (emit_ok) begin
            cmd.emit     = 1'b1;
            cmd.emit_top = 1'b1;
            cmd.pop      = 1'b1;
          end
        end else begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (fin_ok) begin
          cmd.finish = 1'b1;
          in_ready   = 1'b1;
          if (in_valid) begin
            cmd.load   = 1'b1;
            state_next = S_PROC;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[hdl/isp_checker.sv]
// Port-level checker for the infix-to-postfix converter, bound to the top level.
// Depends on isp_pkg and infix_to_postfix_converter.
module isp_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input isp_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input isp_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("out_data changed while stalled");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.expr_done |-> out_data.last_of_run)
    else $error("expr_done without last_of_run");

  a_bare_marker: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.char_valid |->
      out_data.last_of_run && out_data.expr_done && (out_data.out_char == 8'h00))
    else $error("malformed bare end marker");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind infix_to_postfix_converter isp_checker u_isp_checker (.*);
